// ===== src/gdbd_pkg.sv =====
// Shared types, constants and calendar helpers for the days-between-dates block.
`timescale 1ns / 1ps

package gdbd_pkg;

   // Field widths
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 20;
   localparam int ERR_W   = 2;
   // Day number of a year up to 4095 stays below 2^21
   localparam int DNUM_W  = 21;

   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [DAY_W-1:0]   day_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ERR_W-1:0]   err_type;
   typedef logic [DNUM_W-1:0]  dnum_type;

   // Calendar constants
   localparam year_type  FIRST_YEAR = 12'd1582;
   localparam month_type MONTH_MIN  = 4'd1;
   localparam month_type MONTH_MAX  = 4'd12;
   localparam month_type MONTH_FEB  = 4'd2;
   localparam count_type COUNT_MAX  = 20'hFFFFF;

   // Result codes
   localparam err_type ERR_NONE  = 2'd0;
   localparam err_type ERR_EARLY = 2'd1;
   localparam err_type ERR_ORDER = 2'd2;

   // x/25 for x < 1024: x*1311 >> 15 (error stays below 0.01)
   localparam int DIV25_MUL   = 1311;
   localparam int DIV25_SHIFT = 15;

   // Days before month m of a March-based year, m = 0 is March
   function automatic logic [8:0] days_before(input month_type m);
      logic [8:0] d;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== src/gdbd_day_num.sv =====
// Closed-form day number of one Gregorian date, counted with March-based years.
`timescale 1ns / 1ps

module gdbd_day_num import gdbd_pkg::*; (
   input  year_type  year,
   input  month_type month,
   input  day_type   day,
   output dnum_type  day_num
);

   month_type   month_c;
   logic        jan_feb;
   year_type    y;
   month_type   m;
   logic [9:0]  q4;
   logic [7:0]  q16;
   logic [20:0] q100_prod;
   logic [18:0] q400_prod;
   logic [5:0]  q100;
   logic [3:0]  q400;
   logic [20:0] y365;

   // Clamp the month into 1..12
   always_comb begin
      if (month < MONTH_MIN) begin
         month_c = MONTH_MIN;
      end else if (month > MONTH_MAX) begin
         month_c = MONTH_MAX;
      end else begin
         month_c = month;
      end
   end

   // January and February close the previous March-based year
   assign jan_feb = (month_c <= MONTH_FEB);
   assign y       = jan_feb ? (year - 12'd1) : year;
   assign m       = jan_feb ? (month_c + 4'd9) : (month_c - 4'd3);

   // Leap-day terms: y/4, y/100 = (y/4)/25, y/400 = (y/16)/25
   assign q4        = y[YEAR_W-1:2];
   assign q16       = y[YEAR_W-1:4];
   assign q100_prod = 21'(q4) * 21'(DIV25_MUL);
   assign q400_prod = 19'(q16) * 19'(DIV25_MUL);
   assign q100      = q100_prod[DIV25_SHIFT +: 6];
   assign q400      = q400_prod[DIV25_SHIFT +: 4];

   assign y365 = 21'(y) * 21'd365;

   assign day_num = y365 + 21'(q4) - 21'(q100) + 21'(q400)
                  + 21'(days_before(m)) + 21'(day);

endmodule

// ===== src/gregorian_days_between_dates_top.sv =====
// Top level: days between two Gregorian dates, three-stage pipeline.
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ---------------------------------
//  request   req_start_*, req_end_*              word taken when start && !busy
//  response  rsp_day_count, rsp_error_code       one cycle, marked by rsp_valid
//
//  A word is taken every cycle that busy is low; its response passes the input register,
//  the day-number register and the result register, in that order.
//  busy is high only while reset is high; reset clears the stage valid bits.
//  The receiver cannot stall; each response is shown for exactly one cycle.
`timescale 1ns / 1ps

module gregorian_days_between_dates_top import gdbd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  year_type  req_start_year,
   input  month_type req_start_month,
   input  day_type   req_start_day,
   input  year_type  req_end_year,
   input  month_type req_end_month,
   input  day_type   req_end_day,
   output logic      rsp_valid,
   output count_type rsp_day_count,
   output err_type   rsp_error_code
);

   // Stage 1: input register
   logic      s1_valid_ff;
   year_type  s1_sy_ff, s1_ey_ff;
   month_type s1_sm_ff, s1_em_ff;
   day_type   s1_sd_ff, s1_ed_ff;
   logic      accept;

   // Stage 2: day numbers
   logic      s2_valid_ff;
   logic      s2_early_ff;
   dnum_type  s2_a_ff, s2_b_ff;
   dnum_type  a_in, b_in;
   logic      early_in;

   // Stage 3: result register
   logic      rsp_valid_ff;
   count_type rsp_count_ff, rsp_count_in;
   err_type   rsp_err_ff, rsp_err_in;
   dnum_type  diff;

   assign busy   = reset;
   assign accept = start && !busy;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sy_ff <= req_start_year;
         s1_sm_ff <= req_start_month;
         s1_sd_ff <= req_start_day;
         s1_ey_ff <= req_end_year;
         s1_em_ff <= req_end_month;
         s1_ed_ff <= req_end_day;
      end
   end

   gdbd_day_num u_start_num (
      .year    (s1_sy_ff),
      .month   (s1_sm_ff),
      .day     (s1_sd_ff),
      .day_num (a_in)
   );

   gdbd_day_num u_end_num (
      .year    (s1_ey_ff),
      .month   (s1_em_ff),
      .day     (s1_ed_ff),
      .day_num (b_in)
   );

   assign early_in = (s1_sy_ff < FIRST_YEAR) || (s1_ey_ff < FIRST_YEAR);

   always_ff @(posedge clock) begin
      s2_a_ff     <= a_in;
      s2_b_ff     <= b_in;
      s2_early_ff <= early_in;
   end

   // Early-year check, difference, order check, saturation
   assign diff = s2_b_ff - s2_a_ff;

   always_comb begin
      rsp_count_in = '0;
      rsp_err_in   = ERR_NONE;
      if (s2_early_ff) begin
         rsp_err_in = ERR_EARLY;
      end else if (s2_a_ff > s2_b_ff) begin
         rsp_err_in = ERR_ORDER;
      end else if (diff[DNUM_W-1]) begin
         rsp_count_in = COUNT_MAX;
      end else begin
         rsp_count_in = diff[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_day_count  = rsp_count_ff;
   assign rsp_error_code = rsp_err_ff;

endmodule

// ===== src/gdbd_checker.sv =====
// Port-level checks for the days-between-dates block, bound to the top level.
`timescale 1ns / 1ps

module gdbd_checker import gdbd_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      start,
   input logic      busy,
   input year_type  req_start_year,
   input month_type req_start_month,
   input day_type   req_start_day,
   input year_type  req_end_year,
   input month_type req_end_month,
   input day_type   req_end_day,
   input logic      rsp_valid,
   input count_type rsp_day_count,
   input err_type   rsp_error_code
);

   // Every word taken gets a matching response
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("taken word produced no response");

   // No response without a matching word taken before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("response without a matching request");

   // An error response carries a zero count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE) |-> (rsp_day_count == '0))
      else $error("error response with nonzero count");

   // Equal in-range dates give zero with no error
   a_same_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_start_year == req_end_year
                          && req_start_month == req_end_month
                          && req_start_day == req_end_day
                          && req_start_year >= FIRST_YEAR, 3))
      |-> (rsp_day_count == '0 && rsp_error_code == ERR_NONE))
      else $error("equal dates gave a nonzero result");

endmodule

bind gregorian_days_between_dates_top gdbd_checker u_gdbd_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_start_year  (req_start_year),
   .req_start_month (req_start_month),
   .req_start_day   (req_start_day),
   .req_end_year    (req_end_year),
   .req_end_month   (req_end_month),
   .req_end_day     (req_end_day),
   .rsp_valid       (rsp_valid),
   .rsp_day_count   (rsp_day_count),
   .rsp_error_code  (rsp_error_code)
);
